@@ rtl/pwrd_pkg.sv @@
`default_nettype none
package pwrd_pkg;

  // default sizing
  localparam int PWRD_WORKERS = 16;
  localparam int PWRD_DEPTH   = 64;

  // action codes carried by an input beat
  typedef enum logic [2:0] {
    ACT_PUSH_BOT = 3'd0,
    ACT_POP_TOP  = 3'd1,
    ACT_POP_BOT  = 3'd2,
    ACT_PEEK_TOP = 3'd3,
    ACT_PEEK_BOT = 3'd4
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // result fields that travel beside the slot read
  typedef struct packed {
    logic       valid;
    logic       found;
    status_t    status;
    logic [6:0] occupancy;
  } meta_t;

endpackage
`default_nettype wire

@@ rtl/pwrd_slot_ram.sv @@
`default_nettype none
module pwrd_slot_ram #(
  parameter int ENTRIES = 1024,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire logic [15:0]   wdata,
  output logic      [15:0]   rdata
);

  logic [15:0] mem_r [ENTRIES];
  logic [15:0] rdata_r;

  // single port: write a handle or register one read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/pwrd_ctrl.sv @@
`default_nettype none
module pwrd_ctrl #(
  parameter int WORKERS = pwrd_pkg::PWRD_WORKERS,
  parameter int DEPTH   = pwrd_pkg::PWRD_DEPTH,
  localparam int ENTRIES = WORKERS * DEPTH,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [2:0]    action,
  input  wire logic [3:0]    worker,
  input  wire logic [15:0]   task_in,
  output logic               mem_we,
  output logic               mem_re,
  output logic [AW-1:0]      mem_addr,
  output logic [15:0]        mem_wdata,
  output pwrd_pkg::meta_t    meta
);
  import pwrd_pkg::*;

  localparam int WIDX = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int PW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);

  // input register
  logic              s1_valid_r;
  logic [2:0]        s1_action_r;
  logic [3:0]        s1_worker_r;
  logic [15:0]       s1_task_r;

  // per-worker ring pointers and counts
  logic [PW-1:0]     top_r [WORKERS];
  logic [CW-1:0]     cnt_r [WORKERS];

  meta_t             meta_r;
  meta_t             meta_nxt;

  logic [WIDX+3:0]   wk_ext;
  logic [WIDX-1:0]   widx;
  logic              wk_ok;
  logic [PW-1:0]     t_cur;
  logic [CW-1:0]     n_cur;
  logic [PW-1:0]     t_nxt;
  logic [CW-1:0]     n_nxt;
  logic              upd;
  logic [PW-1:0]     pos;
  logic [PW-1:0]     pos_bot;
  logic [PW-1:0]     pos_push;
  logic [PW-1:0]     top_inc;
  logic [CW+6:0]     occ_ext;

  // fold a sum below twice the depth back into the ring
  function automatic logic [PW-1:0] ring_wrap(input logic [PW:0] s);
    logic [PW:0] d;
    d = s - (PW+1)'(DEPTH);
    return (s >= (PW+1)'(DEPTH)) ? d[PW-1:0] : s[PW-1:0];
  endfunction

  // capture the command beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    if (accept) begin
      s1_action_r <= action;
      s1_worker_r <= worker;
      s1_task_r   <= task_in;
    end
  end

  // select the addressed ring
  assign wk_ext = {{WIDX{1'b0}}, s1_worker_r};
  assign widx   = wk_ext[WIDX-1:0];
  assign wk_ok  = (32'(s1_worker_r) < WORKERS);
  assign t_cur  = top_r[widx];
  assign n_cur  = cnt_r[widx];

  // ring positions of the bottom entry, the next free slot and the next top
  assign pos_push = ring_wrap({1'b0, t_cur} + (PW+1)'(n_cur));
  assign pos_bot  = ring_wrap({1'b0, t_cur} + (PW+1)'(n_cur - CW'(1)));
  assign top_inc  = ring_wrap({1'b0, t_cur} + (PW+1)'(1));

  // decode the action against the ring state
  always_comb begin
    t_nxt              = t_cur;
    n_nxt              = n_cur;
    upd                = 1'b0;
    pos                = pos_push;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    meta_nxt.valid     = s1_valid_r;
    meta_nxt.found     = 1'b0;
    meta_nxt.status    = ST_OK;
    if (!wk_ok) begin
      case (action_t'(s1_action_r))
        ACT_PUSH_BOT: meta_nxt.status = ST_FULL;
        ACT_POP_TOP,
        ACT_POP_BOT,
        ACT_PEEK_TOP,
        ACT_PEEK_BOT: meta_nxt.status = ST_EMPTY;
        default:      meta_nxt.status = ST_OK;
      endcase
    end else begin
      case (action_t'(s1_action_r))
        ACT_PUSH_BOT: begin
          if (n_cur >= CW'(DEPTH)) begin
            meta_nxt.status = ST_FULL;
          end else begin
            mem_we = s1_valid_r;
            n_nxt  = n_cur + CW'(1);
            upd    = 1'b1;
          end
        end
        ACT_POP_TOP,
        ACT_POP_BOT,
        ACT_PEEK_TOP,
        ACT_PEEK_BOT: begin
          if (n_cur == '0) begin
            meta_nxt.status = ST_EMPTY;
          end else begin
            meta_nxt.found = 1'b1;
            mem_re         = s1_valid_r;
            if (action_t'(s1_action_r) == ACT_POP_TOP ||
                action_t'(s1_action_r) == ACT_PEEK_TOP) begin
              pos = t_cur;
            end else begin
              pos = pos_bot;
            end
            if (action_t'(s1_action_r) == ACT_POP_TOP) begin
              t_nxt = top_inc;
              n_nxt = n_cur - CW'(1);
              upd   = 1'b1;
            end else if (action_t'(s1_action_r) == ACT_POP_BOT) begin
              n_nxt = n_cur - CW'(1);
              upd   = 1'b1;
            end
          end
        end
        default: begin
          meta_nxt.status = ST_OK;
        end
      endcase
    end
    occ_ext            = {7'b0, n_nxt};
    meta_nxt.occupancy = wk_ok ? occ_ext[6:0] : 7'd0;
  end

  assign mem_addr  = AW'(widx) * AW'(DEPTH) + AW'(pos);
  assign mem_wdata = s1_task_r;

  // write back the ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORKERS; i++) begin
        top_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else if (s1_valid_r && wk_ok && upd) begin
      top_r[widx] <= t_nxt;
      cnt_r[widx] <= n_nxt;
    end
  end

  // hold the result fields alongside the slot read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid <= 1'b0;
    end else begin
      meta_r.valid <= meta_nxt.valid;
    end
    meta_r.found     <= meta_nxt.found;
    meta_r.status    <= meta_nxt.status;
    meta_r.occupancy <= meta_nxt.occupancy;
  end

  assign meta = meta_r;

endmodule
`default_nettype wire

@@ rtl/per_worker_ready_deque.sv @@
// Pipeline: a result beat passes the input register, the meta and slot RAM read registers
//   and the output register before it drives the out_ ports; out_valid is high for exactly one cycle.
// Throughput: one command per cycle; busy stays low, as the ring pointers are written back
//   while the command is decoded and the single-port slot RAM sees one access; the receiver cannot stall.
// Reset: rst_n (synchronous) clears every ring's top and count at once; slot RAM is
//   not cleared and needs no pass, since only pushed slots are ever read.
`default_nettype none
module per_worker_ready_deque #(
  parameter int WORKERS = pwrd_pkg::PWRD_WORKERS,
  parameter int DEPTH   = pwrd_pkg::PWRD_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_action,
  input  wire logic [3:0]  in_worker,
  input  wire logic [15:0] in_task_in,
  output logic             out_valid,
  output logic [15:0]      out_task_out,
  output logic             out_found,
  output logic [1:0]       out_status,
  output logic [6:0]       out_occupancy
);
  import pwrd_pkg::*;

  localparam int ENTRIES = WORKERS * DEPTH;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic          accept;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata;
  logic [15:0]   mem_rdata;
  meta_t         meta;

  logic          out_valid_r;
  logic [15:0]   out_task_out_r;
  logic          out_found_r;
  logic [1:0]    out_status_r;
  logic [6:0]    out_occupancy_r;

  // every cycle can take a command beat
  assign busy   = 1'b0;
  assign accept = start && !busy;

  pwrd_ctrl #(
    .WORKERS (WORKERS),
    .DEPTH   (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (in_action),
    .worker    (in_worker),
    .task_in   (in_task_in),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .meta      (meta)
  );

  pwrd_slot_ram #(
    .ENTRIES (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // register the result beat; zero the handle when nothing was found
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= meta.valid;
    end
    out_task_out_r  <= meta.found ? mem_rdata : 16'd0;
    out_found_r     <= meta.found;
    out_status_r    <= meta.status;
    out_occupancy_r <= meta.occupancy;
  end

  assign out_valid     = out_valid_r;
  assign out_task_out  = out_task_out_r;
  assign out_found     = out_found_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

  // a returned handle always comes with an ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("found set with non-ok status");

  // an empty answer carries no handle and no entries
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> !out_found && out_task_out == 16'd0 &&
      out_occupancy == 7'd0)
    else $error("empty result not clean");

  // each accepted command gives one result beat, after the input, meta and output registers
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) |->
      out_valid == $past(accept, 3))
    else $error("result beat does not match accepted command");

endmodule
`default_nettype wire

@@ dv/per_worker_ready_deque_test.sv @@
`default_nettype none
module per_worker_ready_deque_test;
  import pwrd_pkg::*;

  localparam int WORKERS = PWRD_WORKERS;
  localparam int DEPTH   = PWRD_DEPTH;

  // action codes the block must treat as no-ops
  localparam logic [2:0] ACT_RSVD_LO  = 3'd5;
  localparam logic [2:0] ACT_RSVD_MID = 3'd6;
  localparam logic [2:0] ACT_RSVD_HI  = 3'd7;

  localparam int PHASES          = 8;
  localparam int BEATS_PER_PHASE = 210;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SHOW_LIMIT      = 10;

  // sender idle odds per phase, in percent
  localparam int IDLE_PCT [PHASES] = '{0, 57, 25, 0, 57, 25, 57, 0};
  // push odds per stimulus mix: balanced, fill, drain, steal
  localparam int PUSH_PCT [4] = '{35, 85, 15, 50};

  typedef struct packed {
    logic [15:0] handle;
    logic        found;
    status_t     status;
    logic [6:0]  occ;
  } deque_reply_t;

  typedef struct {
    logic [2:0]   act;
    logic [3:0]   wk;
    logic [15:0]  handle;
    bit           typed;
    deque_reply_t want;
  } op_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_action;
  logic [3:0]  in_worker;
  logic [15:0] in_task_in;
  logic        out_valid;
  logic [15:0] out_task_out;
  logic        out_found;
  logic [1:0]  out_status;
  logic [6:0]  out_occupancy;

  // mirror of every ring
  logic [15:0] ring_slot  [WORKERS][DEPTH];
  int          ring_top   [WORKERS];
  int          ring_count [WORKERS];

  deque_reply_t pending_replies [$];
  op_row_t      dir_rows [$];
  int           fail_count  = 0;
  int           shown_count = 0;
  int           quiet_cycles = 0;

  per_worker_ready_deque uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_worker    (in_worker),
    .in_task_in   (in_task_in),
    .out_valid    (out_valid),
    .out_task_out (out_task_out),
    .out_found    (out_found),
    .out_status   (out_status),
    .out_occupancy(out_occupancy)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // apply one command to the mirrored rings and return its reply
  function automatic deque_reply_t apply_deque_op(logic [2:0] act, logic [3:0] wk,
                                                  logic [15:0] handle);
    deque_reply_t r;
    int top;
    int cnt;
    int pos;
    r = '0;
    r.status = ST_OK;
    if (int'(wk) >= WORKERS) begin
      if (act == ACT_PUSH_BOT) r.status = ST_FULL;
      else if (act <= ACT_PEEK_BOT) r.status = ST_EMPTY;
      return r;
    end
    top = ring_top[wk];
    cnt = ring_count[wk];
    if (act == ACT_PUSH_BOT) begin
      if (cnt >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        ring_slot[wk][(top + cnt) % DEPTH] = handle;
        cnt++;
      end
    end else if (act <= ACT_PEEK_BOT) begin
      if (cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // top-side actions read the oldest entry, bottom-side the newest
        pos = (act == ACT_POP_TOP || act == ACT_PEEK_TOP) ? top : (top + cnt - 1) % DEPTH;
        r.handle = ring_slot[wk][pos];
        r.found  = 1'b1;
        if (act == ACT_POP_TOP) begin
          top = (top + 1) % DEPTH;
          cnt--;
        end else if (act == ACT_POP_BOT) begin
          cnt--;
        end
      end
    end
    ring_top[wk]   = top;
    ring_count[wk] = cnt;
    r.occ = 7'(cnt);
    return r;
  endfunction

  function automatic logic [2:0] pick_action(int mix);
    int r;
    r = $urandom_range(99);
    if (r < 4) return 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
    if (r < 4 + PUSH_PCT[mix]) return ACT_PUSH_BOT;
    return 3'($urandom_range(ACT_POP_TOP, ACT_PEEK_BOT));
  endfunction

  task automatic add_row(input logic [2:0] act, input logic [3:0] wk, input logic [15:0] handle,
                         input bit typed, input logic [15:0] e_handle, input logic e_found,
                         input status_t e_status, input logic [6:0] e_occ);
    op_row_t row;
    row.act         = act;
    row.wk          = wk;
    row.handle      = handle;
    row.typed       = typed;
    row.want.handle = e_handle;
    row.want.found  = e_found;
    row.want.status = e_status;
    row.want.occ    = e_occ;
    dir_rows.push_back(row);
  endtask

  // drive one command beat and hold it until the block takes it
  task automatic send_beat(input logic [2:0] act, input logic [3:0] wk, input logic [15:0] handle,
                           input bit typed, input deque_reply_t want);
    deque_reply_t predicted;
    start      <= 1'b1;
    in_action  <= act;
    in_worker  <= wk;
    in_task_in <= handle;
    do @(posedge clk); while (!(start && !busy));
    predicted = apply_deque_op(act, wk, handle);
    pending_replies.push_back(typed ? want : predicted);
  endtask

  // drop start for the requested idle span, with junk on the fields
  task automatic idle_for(input int cycles);
    start <= 1'b0;
    repeat (cycles) begin
      in_action  <= 3'($urandom);
      in_worker  <= 4'($urandom);
      in_task_in <= 16'($urandom);
      @(posedge clk);
    end
  endtask

  // hold off until every reply has come back
  task automatic wait_replies();
    start <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // compare each reply beat with the oldest prediction
  always @(posedge clk) begin
    deque_reply_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_replies.size() == 0) begin
        fail_count++;
        if (shown_count < SHOW_LIMIT) begin
          shown_count++;
          $display("unexpected reply: task %h found %b status %0d occ %0d",
                   out_task_out, out_found, out_status, out_occupancy);
        end
      end else begin
        exp_r = pending_replies.pop_front();
        if (out_task_out !== exp_r.handle || out_found !== exp_r.found ||
            out_status !== exp_r.status || out_occupancy !== exp_r.occ) begin
          fail_count++;
          if (shown_count < SHOW_LIMIT) begin
            shown_count++;
            $display("reply mismatch: exp task %h found %b status %0d occ %0d",
                     exp_r.handle, exp_r.found, exp_r.status, exp_r.occ);
            $display("                got task %h found %b status %0d occ %0d",
                     out_task_out, out_found, out_status, out_occupancy);
          end
        end
      end
    end
  end

  // end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("per_worker_ready_deque_test: FAIL");
      $finish;
    end
  end

  initial begin
    logic [3:0] hot;
    logic [2:0] act;
    logic [3:0] wk;
    int mix;

    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_action  <= '0;
    in_worker  <= '0;
    in_task_in <= '0;
    for (int w = 0; w < WORKERS; w++) begin
      ring_top[w]   = 0;
      ring_count[w] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty rings, reserved codes, both ends, extreme handles and workers
    add_row(ACT_POP_TOP,  4'd0,  16'h0000, 1, 16'h0000, 0, ST_EMPTY, 7'd0);
    add_row(ACT_POP_BOT,  4'd15, 16'hFFFF, 1, 16'h0000, 0, ST_EMPTY, 7'd0);
    add_row(ACT_PEEK_TOP, 4'd3,  16'h0000, 1, 16'h0000, 0, ST_EMPTY, 7'd0);
    add_row(ACT_PEEK_BOT, 4'd0,  16'h0000, 1, 16'h0000, 0, ST_EMPTY, 7'd0);
    add_row(ACT_RSVD_LO,  4'd0,  16'hFFFF, 1, 16'h0000, 0, ST_OK,    7'd0);
    add_row(ACT_RSVD_HI,  4'd15, 16'h0000, 1, 16'h0000, 0, ST_OK,    7'd0);
    add_row(ACT_PUSH_BOT, 4'd0,  16'hFFFF, 1, 16'h0000, 0, ST_OK,    7'd1);
    add_row(ACT_PUSH_BOT, 4'd0,  16'h0000, 1, 16'h0000, 0, ST_OK,    7'd2);
    add_row(ACT_PUSH_BOT, 4'd0,  16'hA5A5, 1, 16'h0000, 0, ST_OK,    7'd3);
    add_row(ACT_PEEK_TOP, 4'd0,  16'h0000, 1, 16'hFFFF, 1, ST_OK,    7'd3);
    add_row(ACT_PEEK_BOT, 4'd0,  16'h0000, 1, 16'hA5A5, 1, ST_OK,    7'd3);
    add_row(ACT_POP_TOP,  4'd0,  16'h0000, 1, 16'hFFFF, 1, ST_OK,    7'd2);
    add_row(ACT_POP_BOT,  4'd0,  16'h0000, 1, 16'hA5A5, 1, ST_OK,    7'd1);
    add_row(ACT_POP_BOT,  4'd0,  16'h0000, 1, 16'h0000, 1, ST_OK,    7'd0);
    add_row(ACT_POP_TOP,  4'd0,  16'h0000, 1, 16'h0000, 0, ST_EMPTY, 7'd0);
    add_row(ACT_PUSH_BOT, 4'd15, 16'h5A5A, 1, 16'h0000, 0, ST_OK,    7'd1);
    add_row(ACT_RSVD_MID, 4'd15, 16'h1234, 1, 16'h0000, 0, ST_OK,    7'd1);
    add_row(ACT_PUSH_BOT, 4'd15, 16'h8001, 0, 16'h0000, 0, ST_OK,    7'd0);
    add_row(ACT_PEEK_BOT, 4'd15, 16'h0000, 0, 16'h0000, 0, ST_OK,    7'd0);
    add_row(ACT_POP_TOP,  4'd15, 16'h0000, 0, 16'h0000, 0, ST_OK,    7'd0);
    add_row(ACT_POP_TOP,  4'd15, 16'h0000, 0, 16'h0000, 0, ST_OK,    7'd0);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].act, dir_rows[i].wk, dir_rows[i].handle,
                dir_rows[i].typed, dir_rows[i].want);
    wait_replies();

    // random phases: fill one ring past full, drain it, steal across the wrap
    hot = 4'($urandom_range(WORKERS - 1));
    for (int p = 0; p < PHASES; p++) begin
      mix = p % 4;
      if (mix == 1) hot = 4'($urandom_range(WORKERS - 1));
      for (int i = 0; i < BEATS_PER_PHASE; i++) begin
        if (IDLE_PCT[p] != 0 && $urandom_range(99) < IDLE_PCT[p])
          idle_for($urandom_range(1, 3));
        act = pick_action(mix);
        wk  = (mix != 0 && $urandom_range(9) != 0) ? hot : 4'($urandom_range(WORKERS - 1));
        send_beat(act, wk, 16'($urandom), 1'b0, '0);
      end
      wait_replies();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("per_worker_ready_deque_test: PASS");
    end else begin
      $display("per_worker_ready_deque_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
